@@ rtl/core/rhb_pkg.sv @@
// Shared constants, types and helpers for the radial height brush.
`timescale 1ns / 1ps

package rhb_pkg;

    localparam int FRAC_BITS = 8;

    localparam int POS_W    = 20;
    localparam int DT_W     = 16;
    localparam int BH_W     = 8;
    localparam int RAD_W    = 11;
    localparam int LIM_W    = 19;
    localparam int RADF_W   = RAD_W + FRAC_BITS;
    localparam int SQR_W    = 2 * RADF_W;
    localparam int ABS_W    = POS_W;
    localparam int SQ_W     = 2 * ABS_W;
    localparam int DSQ_W    = SQ_W + 1;
    localparam int CMP_W    = (DSQ_W > SQR_W) ? DSQ_W : SQR_W;

    localparam int SQ1_STEPS = (DSQ_W + 1) / 2;
    localparam int SQ1_W     = 2 * SQ1_STEPS;
    localparam int ROOT1_W   = SQ1_STEPS;

    localparam int QF_BITS   = 16;
    localparam int Q_W       = QF_BITS + 1;
    localparam int DIV_STEPS = Q_W;

    localparam int SQ2_STEPS = QF_BITS + 1;
    localparam int SQ2_W     = 2 * SQ2_STEPS;
    localparam int F_W       = SQ2_STEPS;

    localparam int P1_W  = BH_W + F_W;
    localparam int P2_W  = P1_W + DT_W;
    localparam int Y_W   = P2_W + 3;
    localparam int MAG_SHIFT = 2 * QF_BITS - FRAC_BITS;
    localparam int TGT_SHIFT = QF_BITS - FRAC_BITS;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(50 << FRAC_BITS);
    localparam logic [Q_W-1:0]   ONE_Q16     = Q_W'(1) << QF_BITS;

    typedef enum logic [1:0] {
        ZONE_OUT   = 2'd0,
        ZONE_BAND  = 2'd1,
        ZONE_INNER = 2'd2
    } zone_t;

    typedef enum logic [1:0] {
        REG_BRUSH_HEIGHT = 2'd0,
        REG_INNER_RADIUS = 2'd1,
        REG_OUTER_RADIUS = 2'd2,
        REG_HEIGHT_LIMIT = 2'd3
    } reg_addr_t;

    typedef struct packed {
        logic signed [POS_W-1:0] vy;
        logic [DT_W-1:0]         dt;
        logic                    additive;
        zone_t                   zone;
    } side_t;

    function automatic logic signed [POS_W-1:0] sat_y(input logic signed [Y_W-1:0] v);
        logic signed [Y_W-1:0] hi;
        logic signed [Y_W-1:0] lo;
        hi = Y_W'((1 << (POS_W - 1)) - 1);
        lo = -Y_W'(1 << (POS_W - 1));
        if (v > hi)
            sat_y = hi[POS_W-1:0];
        else if (v < lo)
            sat_y = lo[POS_W-1:0];
        else
            sat_y = v[POS_W-1:0];
    endfunction

endpackage

@@ rtl/core/radial_height_brush.sv @@
// Radial height brush: pipelined terrain vertex height update with sqrt falloff.
`timescale 1ns / 1ps
//
// Use: one vertex request (position, height, brush center, time step, mode)
// enters on in_valid while in_stall is low; one new height leaves on
// out_valid / new_y, taken when out_stall is low.
// Brush registers sit on the APB port: 0 brush_height, 4 inner_radius,
// 8 outer_radius, 12 height_limit. Write them while no request is in flight.
// Pipeline: 64 register stages in all, made up of the chain of
// distance square root (21 stages), band ratio divider (17 stages) and
// falloff square root (17 stages), plus 9 stages of arithmetic around them.
// Throughput: one request per cycle while out_stall does not freeze the pipeline.
// Stall: a high out_stall with a result waiting freezes the whole pipeline
// and raises in_stall in the same cycle; nothing is lost or repeated.
// Reset: all valid bits clear, registers return to brush_height 0,
// radii 0, height_limit 50.0.
//
module radial_height_brush
    import rhb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [POS_W-1:0] vertex_x,
    input  logic signed [POS_W-1:0] vertex_z,
    input  logic signed [POS_W-1:0] vertex_y,
    input  logic signed [POS_W-1:0] center_x,
    input  logic signed [POS_W-1:0] center_z,
    input  logic [DT_W-1:0]         time_step,
    input  logic                    additive_mode,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] new_y
);

    logic [BH_W-1:0]  brush_height_reg;
    logic [RAD_W-1:0] inner_radius_reg;
    logic [RAD_W-1:0] outer_radius_reg;
    logic [LIM_W-1:0] height_limit_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_height_reg <= '0;
            inner_radius_reg <= '0;
            outer_radius_reg <= '0;
            height_limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_addr_t'(paddr[3:2]))
                REG_BRUSH_HEIGHT: brush_height_reg <= pwdata[BH_W-1:0];
                REG_INNER_RADIUS: inner_radius_reg <= pwdata[RAD_W-1:0];
                REG_OUTER_RADIUS: outer_radius_reg <= pwdata[RAD_W-1:0];
                REG_HEIGHT_LIMIT: height_limit_reg <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_addr_t'(paddr[3:2]))
            REG_BRUSH_HEIGHT: prdata = 32'(brush_height_reg);
            REG_INNER_RADIUS: prdata = 32'(inner_radius_reg);
            REG_OUTER_RADIUS: prdata = 32'(outer_radius_reg);
            REG_HEIGHT_LIMIT: prdata = 32'(height_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // Pipeline control
    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    logic [RADF_W-1:0] in_f;
    logic [RADF_W-1:0] out_f;
    logic [RADF_W-1:0] den;

    assign in_f  = {inner_radius_reg, FRAC_BITS'(0)};
    assign out_f = {outer_radius_reg, FRAC_BITS'(0)};
    assign den   = out_f - in_f;

    // Stage A: absolute differences
    logic signed [POS_W:0] dx_next;
    logic signed [POS_W:0] dz_next;
    logic                  va_reg;
    logic [ABS_W-1:0]      ax_reg;
    logic [ABS_W-1:0]      az_reg;
    side_t                 sa_reg;

    assign dx_next = {vertex_x[POS_W-1], vertex_x} - {center_x[POS_W-1], center_x};
    assign dz_next = {vertex_z[POS_W-1], vertex_z} - {center_z[POS_W-1], center_z};

    // Stage B: squares; stage C: sum; stage D: zone
    logic             vb_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqz_reg;
    side_t            sb_reg;
    logic [SQR_W-1:0] in_sq_reg;
    logic [SQR_W-1:0] out_sq_reg;
    logic             vc_reg;
    logic [DSQ_W-1:0] dsq_reg;
    side_t            sc_reg;
    zone_t            zone_next;

    always_comb
    begin
        if (CMP_W'(dsq_reg) <= CMP_W'(in_sq_reg))
            zone_next = ZONE_INNER;
        else if (CMP_W'(dsq_reg) <= CMP_W'(out_sq_reg))
            zone_next = ZONE_BAND;
        else
            zone_next = ZONE_OUT;
    end

    // Distance square root
    logic             v1_reg  [0:SQ1_STEPS];
    logic [SQ1_W-1:0] n1_reg  [0:SQ1_STEPS];
    logic [SQ1_W-1:0] r1_reg  [0:SQ1_STEPS];
    side_t            sd1_reg [0:SQ1_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            v1_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= in_valid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            v1_reg[0] <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_sq_reg  <= SQR_W'(in_f) * SQR_W'(in_f);
        out_sq_reg <= SQR_W'(out_f) * SQR_W'(out_f);
        if (en)
        begin
            ax_reg      <= dx_next[POS_W] ? ABS_W'(-dx_next) : dx_next[ABS_W-1:0];
            az_reg      <= dz_next[POS_W] ? ABS_W'(-dz_next) : dz_next[ABS_W-1:0];
            sa_reg.vy       <= vertex_y;
            sa_reg.dt       <= time_step;
            sa_reg.additive <= additive_mode;
            sa_reg.zone     <= ZONE_OUT;
            sqx_reg     <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqz_reg     <= SQ_W'(az_reg) * SQ_W'(az_reg);
            sb_reg      <= sa_reg;
            dsq_reg     <= DSQ_W'(sqx_reg) + DSQ_W'(sqz_reg);
            sc_reg      <= sb_reg;
            n1_reg[0]   <= SQ1_W'(dsq_reg);
            r1_reg[0]   <= '0;
            sd1_reg[0].vy       <= sc_reg.vy;
            sd1_reg[0].dt       <= sc_reg.dt;
            sd1_reg[0].additive <= sc_reg.additive;
            sd1_reg[0].zone     <= zone_next;
        end
    end

    for (genvar s = 1; s <= SQ1_STEPS; s++)
    begin : g_sq1
        localparam logic [SQ1_W:0] BIT = (SQ1_W + 1)'(1) << (2 * (SQ1_STEPS - s));
        logic [SQ1_W:0] trial;

        assign trial = {1'b0, r1_reg[s-1]} + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v1_reg[s] <= 1'b0;
            else if (en)
                v1_reg[s] <= v1_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd1_reg[s] <= sd1_reg[s-1];
                if ({1'b0, n1_reg[s-1]} >= trial)
                begin
                    n1_reg[s] <= n1_reg[s-1] - trial[SQ1_W-1:0];
                    r1_reg[s] <= (r1_reg[s-1] >> 1) + BIT[SQ1_W-1:0];
                end
                else
                begin
                    n1_reg[s] <= n1_reg[s-1];
                    r1_reg[s] <= r1_reg[s-1] >> 1;
                end
            end
        end
    end

    // Band ratio divider
    logic [ROOT1_W-1:0] dist_root;
    logic [RADF_W-1:0]  num_next;

    assign dist_root = r1_reg[SQ1_STEPS][ROOT1_W-1:0];
    assign num_next  = (ROOT1_W'(out_f) > dist_root) ?
                       RADF_W'(ROOT1_W'(out_f) - dist_root) : '0;

    logic              v2_reg  [0:DIV_STEPS];
    logic [RADF_W-1:0] rem_reg [0:DIV_STEPS];
    logic [Q_W-1:0]    q_reg   [0:DIV_STEPS];
    logic              nb_reg  [0:DIV_STEPS];
    side_t             sd2_reg [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg[0] <= 1'b0;
        else if (en)
            v2_reg[0] <= v1_reg[SQ1_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_next >> 1;
            nb_reg[0]  <= num_next[0];
            q_reg[0]   <= '0;
            sd2_reg[0] <= sd1_reg[SQ1_STEPS];
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        logic [RADF_W:0] t;

        assign t = {rem_reg[j-1], (j == 1) ? nb_reg[j-1] : 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v2_reg[j] <= 1'b0;
            else if (en)
                v2_reg[j] <= v2_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd2_reg[j] <= sd2_reg[j-1];
                nb_reg[j]  <= nb_reg[j-1];
                if (t >= {1'b0, den})
                begin
                    rem_reg[j] <= RADF_W'(t - {1'b0, den});
                    q_reg[j]   <= {q_reg[j-1][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= t[RADF_W-1:0];
                    q_reg[j]   <= {q_reg[j-1][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // Falloff square root
    logic [Q_W-1:0] ratio;

    assign ratio = (q_reg[DIV_STEPS] > ONE_Q16) ? ONE_Q16 : q_reg[DIV_STEPS];

    logic             v3_reg  [0:SQ2_STEPS];
    logic [SQ2_W-1:0] n2_reg  [0:SQ2_STEPS];
    logic [SQ2_W-1:0] r2_reg  [0:SQ2_STEPS];
    side_t            sd3_reg [0:SQ2_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg[0] <= 1'b0;
        else if (en)
            v3_reg[0] <= v2_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg[0]  <= SQ2_W'({ratio, QF_BITS'(0)});
            r2_reg[0]  <= '0;
            sd3_reg[0] <= sd2_reg[DIV_STEPS];
        end
    end

    for (genvar s = 1; s <= SQ2_STEPS; s++)
    begin : g_sq2
        localparam logic [SQ2_W:0] BIT = (SQ2_W + 1)'(1) << (2 * (SQ2_STEPS - s));
        logic [SQ2_W:0] trial;

        assign trial = {1'b0, r2_reg[s-1]} + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v3_reg[s] <= 1'b0;
            else if (en)
                v3_reg[s] <= v3_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd3_reg[s] <= sd3_reg[s-1];
                if ({1'b0, n2_reg[s-1]} >= trial)
                begin
                    n2_reg[s] <= n2_reg[s-1] - trial[SQ2_W-1:0];
                    r2_reg[s] <= (r2_reg[s-1] >> 1) + BIT[SQ2_W-1:0];
                end
                else
                begin
                    n2_reg[s] <= n2_reg[s-1];
                    r2_reg[s] <= r2_reg[s-1] >> 1;
                end
            end
        end
    end

    // Scaling and final update
    side_t           s3;
    logic [F_W-1:0]  f_next;
    logic [BH_W-1:0] mag_s;

    assign s3     = sd3_reg[SQ2_STEPS];
    assign f_next = (s3.zone == ZONE_INNER) ? ONE_Q16 : r2_reg[SQ2_STEPS][F_W-1:0];
    assign mag_s  = (brush_height_reg == '0) ? BH_W'(1) : brush_height_reg;

    logic            vg_reg;
    logic [P1_W-1:0] p1_reg;
    logic [P1_W-1:0] tgt_g_reg;
    side_t           sg_reg;
    logic            vh_reg;
    logic [P2_W-1:0] p2_reg;
    logic [P1_W-1:0] tgt_h_reg;
    side_t           sh_reg;
    logic signed [POS_W-1:0] new_y_reg;

    logic [P2_W-1:0]       mag;
    logic signed [Y_W-1:0] ys;
    logic signed [Y_W-1:0] ya;
    logic signed [Y_W-1:0] yt;
    logic signed [POS_W-1:0] new_y_next;

    assign mag = p2_reg >> MAG_SHIFT;

    always_comb
    begin
        ys = Y_W'(sh_reg.vy);
        ya = ys;
        yt = Y_W'(tgt_h_reg);
        new_y_next = sh_reg.vy;
        if (sh_reg.additive)
        begin
            if (sh_reg.zone != ZONE_OUT)
            begin
                if (brush_height_reg == '0)
                    ya = ys - Y_W'(mag);
                else
                    ya = ys + Y_W'(mag);
            end
            if (ya < 0)
                new_y_next = '0;
            else if (ya > Y_W'(height_limit_reg))
                new_y_next = POS_W'(height_limit_reg);
            else
                new_y_next = ya[POS_W-1:0];
        end
        else
        begin
            case (sh_reg.zone)
                ZONE_INNER: new_y_next = sat_y(Y_W'({brush_height_reg, FRAC_BITS'(0)}));
                ZONE_BAND:  new_y_next = sat_y((ys < yt) ? yt : ys);
                default:    new_y_next = sh_reg.vy;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg        <= 1'b0;
            vh_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vg_reg        <= v3_reg[SQ2_STEPS];
            vh_reg        <= vg_reg;
            out_valid_reg <= vh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= P1_W'(mag_s) * P1_W'(f_next);
            tgt_g_reg <= (P1_W'(brush_height_reg) * P1_W'(f_next)) >> TGT_SHIFT;
            sg_reg    <= s3;
            p2_reg    <= P2_W'(p1_reg) * P2_W'(sg_reg.dt);
            tgt_h_reg <= tgt_g_reg;
            sh_reg    <= sg_reg;
            new_y_reg <= new_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_y     = new_y_reg;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the radial height brush: directed and random vertex requests.
`timescale 1ns / 1ps

module tb_top;
    import rhb_pkg::*;

    localparam int LATENCY = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_z;
    logic signed [POS_W-1:0] vertex_y;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_z;
    logic [DT_W-1:0]         time_step;
    logic                    additive_mode;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [POS_W-1:0] new_y;

    radial_height_brush u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_x(vertex_x), .vertex_z(vertex_z), .vertex_y(vertex_y),
        .center_x(center_x), .center_z(center_z), .time_step(time_step),
        .additive_mode(additive_mode),
        .out_valid(out_valid), .out_stall(out_stall), .new_y(new_y)
    );

    // brush settings mirrored in the testbench
    logic [BH_W-1:0]  cfg_height;
    logic [RAD_W-1:0] cfg_inner;
    logic [RAD_W-1:0] cfg_outer;
    logic [LIM_W-1:0] cfg_limit;

    logic signed [POS_W-1:0] expected_heights[$];
    int  mismatches;
    bit  timed_out;
    int  idle_cycles;
    bit  in_quiet;
    bit  out_quiet;
    bit  hold_out;
    int  in_idle_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [POS_W-1:0] brushed_height(
        input logic signed [POS_W-1:0] vx, input logic signed [POS_W-1:0] vz,
        input logic signed [POS_W-1:0] vy, input logic signed [POS_W-1:0] cx,
        input logic signed [POS_W-1:0] cz, input logic [DT_W-1:0] dt,
        input logic add);
        longint ax;
        longint az;
        longint unsigned dsq;
        longint unsigned rin;
        longint unsigned rout;
        longint unsigned droot;
        longint unsigned num;
        longint unsigned ratio;
        longint unsigned fall;
        longint unsigned mag;
        longint y;
        longint tgt;
        zone_t zone;
        ax = longint'(vx) - longint'(cx);
        az = longint'(vz) - longint'(cz);
        if (ax < 0) ax = -ax;
        if (az < 0) az = -az;
        dsq = ax * ax + az * az;
        rin = longint'(cfg_inner) << FRAC_BITS;
        rout = longint'(cfg_outer) << FRAC_BITS;
        zone = ZONE_OUT;
        fall = 0;
        if (dsq <= rin * rin)
        begin
            zone = ZONE_INNER;
            fall = 65536;
        end
        else if (dsq <= rout * rout)
        begin
            droot = int_sqrt(dsq);
            num = (rout > droot) ? rout - droot : 0;
            ratio = (num << 16) / (rout - rin);
            if (ratio > 65536) ratio = 65536;
            fall = int_sqrt(ratio << 16);
            zone = ZONE_BAND;
        end
        y = vy;
        if (add)
        begin
            if (zone != ZONE_OUT)
            begin
                mag = ((cfg_height == 0 ? 64'd1 : 64'(cfg_height)) * fall * dt) >> MAG_SHIFT;
                if (cfg_height == 0) y = y - longint'(mag);
                else y = y + longint'(mag);
            end
            if (y < 0) y = 0;
            if (y > longint'(cfg_limit)) y = cfg_limit;
        end
        else if (zone == ZONE_INNER)
            y = longint'(cfg_height) << FRAC_BITS;
        else if (zone == ZONE_BAND)
        begin
            tgt = longint'((64'(cfg_height) * fall) >> TGT_SHIFT);
            if (y < tgt) y = tgt;
        end
        if (y > 524287) y = 524287;
        if (y < -524288) y = -524288;
        return y[POS_W-1:0];
    endfunction

    task automatic write_reg(input reg_addr_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BRUSH_HEIGHT: cfg_height = value[BH_W-1:0];
            REG_INNER_RADIUS: cfg_inner = value[RAD_W-1:0];
            REG_OUTER_RADIUS: cfg_outer = value[RAD_W-1:0];
            REG_HEIGHT_LIMIT: cfg_limit = value[LIM_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_brush(input int h, input int ri, input int ro, input int lim);
        write_reg(REG_BRUSH_HEIGHT, h);
        write_reg(REG_INNER_RADIUS, ri);
        write_reg(REG_OUTER_RADIUS, ro);
        write_reg(REG_HEIGHT_LIMIT, lim);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_heights.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic send_vertex(input logic signed [POS_W-1:0] vx,
        input logic signed [POS_W-1:0] vz, input logic signed [POS_W-1:0] vy,
        input logic signed [POS_W-1:0] cx, input logic signed [POS_W-1:0] cz,
        input logic [DT_W-1:0] dt, input logic add);
        while (!in_quiet && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vertex_x <= vx;
        vertex_z <= vz;
        vertex_y <= vy;
        center_x <= cx;
        center_z <= cz;
        time_step <= dt;
        additive_mode <= add;
        do @(posedge clk); while (in_stall && !timed_out);
        expected_heights.push_back(brushed_height(vx, vz, vy, cx, cz, dt, add));
    endtask

    // vertex near the center, offset within about the outer radius
    task automatic send_near(input bit add);
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cz;
        int span;
        span = (int'(cfg_outer) + 2) << FRAC_BITS;
        cx = POS_W'($urandom);
        cz = POS_W'($urandom);
        send_vertex(cx + POS_W'($urandom_range(2 * span) - span),
                    cz + POS_W'($urandom_range(2 * span) - span),
                    $urandom_range(99) < 20 ? POS_W'($urandom) : POS_W'($urandom_range(20000)),
                    cx, cz, DT_W'($urandom), add);
    endtask

    task automatic test_directed();
        set_brush(255, 2047, 2047, 524287);
        send_vertex(0, 0, 0, 0, 0, 16'hFFFF, 1'b1);
        send_vertex(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000, 16'hFFFF, 1'b1);
        send_vertex(20'sh80000, 0, 20'sh80000, 20'sh7FFFF, 0, 0, 1'b0);
        send_vertex(100, 100, -5, 100, 100, 16'h8000, 1'b0);
        drain();
        set_brush(0, 0, 10, 12800);
        send_vertex(0, 0, 1000, 0, 0, 16'hFFFF, 1'b1);
        send_vertex(1, 0, 1000, 0, 0, 16'hFFFF, 1'b1);
        send_vertex(5 << FRAC_BITS, 0, 300, 0, 0, 16'hFFFF, 1'b1);
        send_vertex(10 << FRAC_BITS, 0, 300, 0, 0, 16'hFFFF, 1'b1);
        send_vertex(20 << FRAC_BITS, 0, 20000, 0, 0, 16'h1234, 1'b1);
        send_vertex(20 << FRAC_BITS, 0, -300, 0, 0, 16'h1234, 1'b1);
        send_vertex(3 << FRAC_BITS, 4 << FRAC_BITS, -7, 0, 0, 0, 1'b0);
        drain();
        set_brush(200, 20, 5, 0);
        send_vertex(15 << FRAC_BITS, 0, 77, 0, 0, 16'h4000, 1'b0);
        send_vertex(21 << FRAC_BITS, 0, 77, 0, 0, 16'h4000, 1'b0);
        send_vertex(15 << FRAC_BITS, 0, 77, 0, 0, 16'h4000, 1'b1);
        send_vertex(50 << FRAC_BITS, 0, 77, 0, 0, 16'h4000, 1'b1);
        drain();
        set_brush(100, 4, 30, 524287);
        send_vertex(10 << FRAC_BITS, 0, -100, 0, 0, 16'hFFFF, 1'b0);
        send_vertex(10 << FRAC_BITS, 0, 30000, 0, 0, 16'hFFFF, 1'b0);
        send_vertex(29 << FRAC_BITS, 0, 0, 0, 0, 16'hFFFF, 1'b1);
        drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++)
        begin
            set_brush($urandom_range(255), $urandom_range(40), $urandom_range(60),
                      ph == 5 ? $urandom_range(524287) : $urandom_range(60000));
            for (int i = 0; i < 200; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_vertex(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                                POS_W'($urandom), POS_W'($urandom), DT_W'($urandom),
                                1'($urandom_range(1)));
                else
                    send_near(1'($urandom_range(1)));
            end
            drain();
        end
    endtask

    task automatic test_no_idle();
        set_brush(0, 8, 16, 524287);
        in_quiet = 1'b1;
        out_quiet = 1'b1;
        repeat (300) send_near(1'($urandom_range(1)));
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        set_brush(255, 2, 2047, 524287);
        hold_out = 1'b1;
        in_quiet = 1'b1;
        repeat (300) send_near(1'($urandom_range(1)));
        in_quiet = 1'b0;
        drain();
    endtask

    // long receiver hold-off while requests keep coming
    always @(posedge clk)
    begin
        if (hold_out)
        begin
            out_stall <= 1'b1;
            repeat (200) @(posedge clk);
            hold_out <= 1'b0;
        end
        else
            out_stall <= !out_quiet && $urandom_range(99) < 33;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_heights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result new_y=%0d", new_y);
            end
            else
            begin
                logic signed [POS_W-1:0] exp_y;
                exp_y = expected_heights.pop_front();
                if (new_y !== exp_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("new_y mismatch: expected %0d got %0d", exp_y, new_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else if (expected_heights.size() != 0 || in_valid)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            timed_out = 1'b1;
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        vertex_x = '0;
        vertex_z = '0;
        vertex_y = '0;
        center_x = '0;
        center_z = '0;
        time_step = '0;
        additive_mode = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        timed_out = 1'b0;
        idle_cycles = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        hold_out = 1'b0;
        in_idle_pct = 33;
        cfg_height = '0;
        cfg_inner = '0;
        cfg_outer = '0;
        cfg_limit = LIMIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_settings();
        test_no_idle();
        test_backpressure();
        drain();
        if (mismatches == 0 && expected_heights.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rhb_pkg.sv
rtl/core/radial_height_brush.sv
dv/tb_top.sv
